FILE: design/tccw_pkg.sv
`default_nettype none
package tccw_pkg;

  localparam int FUNC_W = 2;
  localparam int CODE_W = 8;
  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CODE_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CODE_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CODE_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CODE_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_address;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CELL_W-1:0] read_data;
  } rsp_t;

  typedef struct packed {
    logic latch;
    logic put;
    logic clear_home;
    logic copy;
    logic fill;
    logic init_blank;
    logic cnt_zero;
    logic cnt_row;
    logic read;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic scroll_needed;
    logic copy_done;
    logic row_fill_last;
    logic all_fill_last;
  } status_t;

endpackage
`default_nettype wire

FILE: design/tccw_ctrl.sv
`default_nettype none
module tccw_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tccw_pkg::FUNC_W-1:0]  func_i,
  input  wire tccw_pkg::status_t            status_i,
  output tccw_pkg::cmd_t                    cmd_o,
  output logic                              busy_o,
  output logic                              done_o
);

  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_PUT    = 8'b0000_0100,
    S_COPY   = 8'b0000_1000,
    S_FILL   = 8'b0001_0000,
    S_CLEAR  = 8'b0010_0000,
    S_READ   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill       = 1'b1;
        cmd_o.init_blank = 1'b1;
        if (status_i.all_fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          unique case (func_i)
            tccw_pkg::FUNC_PUT: begin
              state_d = S_PUT;
            end
            tccw_pkg::FUNC_CLEAR: begin
              cmd_o.cnt_zero = 1'b1;
              state_d        = S_CLEAR;
            end
            tccw_pkg::FUNC_READ: begin
              state_d = S_READ;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        if (status_i.scroll_needed) begin
          cmd_o.cnt_zero = 1'b1;
          state_d        = S_COPY;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (status_i.copy_done) begin
          cmd_o.cnt_row = 1'b1;
          state_d       = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.row_fill_last) begin
          state_d = S_FINISH;
        end
      end
      S_CLEAR: begin
        cmd_o.fill       = 1'b1;
        cmd_o.clear_home = 1'b1;
        if (status_i.all_fill_last) begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.load_result = 1'b1;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FINISH);
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

endmodule
`default_nettype wire

FILE: design/tccw_datapath.sv
`default_nettype none
module tccw_datapath #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tccw_pkg::req_t               req_i,
  input  wire tccw_pkg::cmd_t               cmd_i,
  input  wire logic                         attr_we_i,
  input  wire logic [tccw_pkg::ATTR_W-1:0]  attr_i,
  output tccw_pkg::status_t                 status_o,
  output tccw_pkg::rsp_t                    rsp_o
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELLS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);
  localparam int PW         = $clog2(TAB_WIDTH);
  localparam int NCW        = $clog2(COLUMNS + TAB_WIDTH);
  localparam int COPY_COUNT = (ROWS - 2) * COLUMNS;
  localparam int ROW_LAST   = (ROWS - 1) * COLUMNS - 1;
  localparam int AFW        = tccw_pkg::ADDR_W;
  localparam int CFW        = tccw_pkg::COL_W;
  localparam int RFW        = tccw_pkg::ROW_W;
  localparam int XW         = (AW > AFW) ? AW : AFW;

  tccw_pkg::req_t                req_q;
  tccw_pkg::rsp_t                rsp_q;
  logic [CW-1:0]                 col_q;
  logic [RW-1:0]                 row_q;
  logic [PW-1:0]                 phase_q;
  logic [tccw_pkg::ATTR_W-1:0]   attr_q;
  logic [AW-1:0]                 cnt_q;
  logic                          scrolled_q;
  logic [tccw_pkg::CELL_W-1:0]   rdata_q;
  logic [tccw_pkg::CELL_W-1:0]   mem [CELLS];

  logic [NCW-1:0]                ncol;
  logic [PW-1:0]                 nphase;
  logic [RW-1:0]                 nrow;
  logic                          wr_char;
  logic                          need_scroll;
  logic [AW-1:0]                 cur_idx;
  logic [XW-1:0]                 addr_ext;
  logic                          in_range;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [tccw_pkg::CELL_W-1:0]   wdata;
  logic [tccw_pkg::CELL_W-1:0]   blank;
  logic                          re;
  logic [AW-1:0]                 raddr;

  assign cur_idx  = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign addr_ext = XW'(req_q.cell_address);
  assign in_range = (addr_ext < XW'(CELLS));

  always_comb begin
    ncol    = NCW'(col_q);
    nphase  = phase_q;
    nrow    = row_q;
    wr_char = 1'b0;
    priority if (req_q.char_code == tccw_pkg::CODE_BS) begin
      if (col_q != '0) begin
        ncol   = NCW'(col_q) - NCW'(1);
        nphase = (phase_q == '0) ? PW'(TAB_WIDTH - 1) : phase_q - PW'(1);
      end
    end else if (req_q.char_code == tccw_pkg::CODE_TAB) begin
      ncol   = NCW'(col_q) + (NCW'(TAB_WIDTH) - NCW'(phase_q));
      nphase = '0;
    end else if (req_q.char_code == tccw_pkg::CODE_CR) begin
      ncol   = '0;
      nphase = '0;
    end else if (req_q.char_code == tccw_pkg::CODE_LF) begin
      ncol   = '0;
      nphase = '0;
      nrow   = row_q + RW'(1);
    end else if (req_q.char_code >= tccw_pkg::CODE_SPACE) begin
      wr_char = 1'b1;
      ncol    = NCW'(col_q) + NCW'(1);
      nphase  = (phase_q == PW'(TAB_WIDTH - 1)) ? '0 : phase_q + PW'(1);
    end
    if (ncol >= NCW'(COLUMNS)) begin
      ncol   = '0;
      nphase = '0;
      nrow   = row_q + RW'(1);
    end
    need_scroll = (nrow == RW'(ROWS - 1));
  end

  assign blank = cmd_i.init_blank ? {tccw_pkg::ATTR_RESET, tccw_pkg::CODE_SPACE}
                                  : {attr_q, tccw_pkg::CODE_SPACE};

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = blank;
    if (cmd_i.put && wr_char) begin
      we    = 1'b1;
      waddr = cur_idx;
      wdata = {attr_q, req_q.char_code};
    end else if (cmd_i.copy && (cnt_q != '0)) begin
      we    = 1'b1;
      waddr = cnt_q - AW'(1);
      wdata = rdata_q;
    end else if (cmd_i.fill) begin
      we = 1'b1;
    end
  end

  assign re    = (cmd_i.copy && (cnt_q < AW'(COPY_COUNT))) || (cmd_i.read && in_range);
  assign raddr = cmd_i.copy ? cnt_q + AW'(COLUMNS) : addr_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
    if (cmd_i.load_result) begin
      rsp_q.cursor_address <= AFW'(cur_idx);
      rsp_q.cursor_column  <= CFW'(col_q);
      rsp_q.cursor_row     <= RFW'(row_q);
      rsp_q.scrolled       <= scrolled_q;
      rsp_q.read_data      <= (req_q.func == tccw_pkg::FUNC_READ && in_range) ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      phase_q    <= '0;
      attr_q     <= tccw_pkg::ATTR_RESET;
      cnt_q      <= '0;
      scrolled_q <= 1'b0;
    end else begin
      if (attr_we_i) begin
        attr_q <= attr_i;
      end
      if (cmd_i.clear_home) begin
        col_q   <= '0;
        row_q   <= '0;
        phase_q <= '0;
      end else if (cmd_i.put) begin
        col_q   <= CW'(ncol);
        row_q   <= need_scroll ? RW'(ROWS - 2) : nrow;
        phase_q <= nphase;
      end
      if (cmd_i.latch) begin
        scrolled_q <= 1'b0;
      end else if (cmd_i.put) begin
        scrolled_q <= need_scroll;
      end
      if (cmd_i.cnt_zero) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_row) begin
        cnt_q <= AW'(COPY_COUNT);
      end else if (cmd_i.copy || cmd_i.fill) begin
        cnt_q <= cnt_q + AW'(1);
      end
    end
  end

  assign status_o.scroll_needed = need_scroll;
  assign status_o.copy_done     = (cnt_q == AW'(COPY_COUNT));
  assign status_o.row_fill_last = (cnt_q == AW'(ROW_LAST));
  assign status_o.all_fill_last = (cnt_q == AW'(CELLS - 1));
  assign rsp_o                  = rsp_q;

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(col_q) < COLUMNS)
    else $error("cursor column beyond the last column");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(row_q) <= ROWS - 2)
    else $error("cursor rests on the bottom row");

  a_copy_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.copy && we |-> int'(waddr) < COPY_COUNT)
    else $error("scroll copy writes outside the moved rows");

endmodule
`default_nettype wire

FILE: design/text_console_character_writer_top.sv
`default_nettype none
// A put-character or read request is latched when accepted and runs its PUT or READ state, then
// FINISH, which loads the result; the next request is taken while the result strobe shows. An
// unused code goes straight to FINISH. A scroll adds a copy state that moves the rows up and a
// fill state that blanks a row, one cell per cycle each; a clear fills every cell, one cell per
// cycle, in place of the put state. After reset the store is swept to blanks while busy stays
// high; attribute writes are taken at any time. Results are strobed for one cycle and cannot stall.
module text_console_character_writer_top #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  input  wire tccw_pkg::req_t               req_i,
  output logic                              busy,
  output logic                              done_o,
  output tccw_pkg::rsp_t                    rsp_o,
  input  wire logic                         cfg_valid_i,
  input  wire logic [tccw_pkg::ATTR_W-1:0]  cfg_data_i,
  output logic                              cfg_ready_o
);

  tccw_pkg::cmd_t    cmd;
  tccw_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  tccw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .func_i   (req_i.func),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  tccw_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cmd_i     (cmd),
    .attr_we_i (cfg_valid_i && cfg_ready_o),
    .attr_i    (cfg_data_i),
    .status_o  (status),
    .rsp_o     (rsp_o)
  );

endmodule
`default_nettype wire
